// ===== hdl/delta_list_timer_queue_macros.svh =====
// assertion macros for the delta list timer queue checker
// no dependencies; pulled in by the checker file
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

// condition in the same cycle
`define DLTQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dltq assertion failed");

// condition in the following cycle
`define DLTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dltq assertion failed");

`endif

// ===== hdl/dltq_pkg.sv =====
// shared types and constants for the delta list timer queue
// no dependencies
package dltq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;
  localparam int ADDR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int GAP_W        = 48;
  localparam int TIME_W       = 63;
  localparam int ENTRIES_W    = 5;

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_ADVANCE  = 2'd1,
    CMD_POP      = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOT_DUE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_INSERT,
    S_POP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       task_id;
    logic [GAP_W-1:0] delay;
    logic             at_tail;
    logic             virt_task;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [7:0]           out_task_id;
    logic                 out_virtual;
    logic [GAP_W-1:0]     advanced_by;
    logic [TIME_W-1:0]    now;
    logic                 real_remaining;
    logic                 step_done;
    logic [ENTRIES_W-1:0] entries;
  } rsp_t;

  typedef struct packed {
    logic                    virt;
    logic [GAP_W-1:0]        gap;
    logic [TASK_ID_BITS-1:0] task_id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/dltq_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module dltq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dltq_seq.sv =====
// command sequencer: scans, shifts and rewrites the delta list in the ram
// depends on dltq_pkg
module dltq_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  dltq_pkg::cmd_item_t        cmd_item,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  output dltq_pkg::rsp_t             res,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       ram_we,
  output logic [dltq_pkg::ADDR_W-1:0] ram_waddr,
  output dltq_pkg::entry_t           ram_wdata,
  output logic [dltq_pkg::ADDR_W-1:0] ram_raddr,
  input  dltq_pkg::entry_t           ram_rdata
);

  localparam int CW = dltq_pkg::CNT_W;
  localparam int AW = dltq_pkg::ADDR_W;
  localparam int GW = dltq_pkg::GAP_W;
  localparam int TW = dltq_pkg::TIME_W;

  dltq_pkg::state_e state, state_next;

  dltq_pkg::cmd_item_t c;
  logic [CW-1:0] cnt, real_cnt, idx, pos;
  logic [TW-1:0] now;
  logic [dltq_pkg::TASK_ID_BITS-1:0] head_task;
  logic [GW-1:0] head_gap, prior, new_gap, r_adv;
  logic          head_virt, r_ovirt;
  logic [1:0]    r_status;
  logic [7:0]    r_oid;

  logic [CW-1:0] idx_inc, idx_dec, cnt_dec;
  logic [GW:0]   due;
  logic          stop;
  logic [TW:0]   sum_now;
  logic          full;

  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);
  assign cnt_dec = cnt - CW'(1);
  assign due     = {1'b0, prior} + {1'b0, ram_rdata.gap};
  // at_tail places the task behind entries due at the same time
  assign stop    = c.at_tail ? (due > {1'b0, c.delay}) : (due >= {1'b0, c.delay});
  assign sum_now = {1'b0, now} + (TW + 1)'(head_gap);
  assign full    = (cnt == CW'(dltq_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dltq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    case (state)
      dltq_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = dltq_pkg::S_EXEC;
        end
      end
      dltq_pkg::S_EXEC: begin
        case (c.cmd)
          dltq_pkg::CMD_SCHEDULE: begin
            if (full) begin
              state_next = dltq_pkg::S_DONE;
            end else if (cnt == '0) begin
              state_next = dltq_pkg::S_INSERT;
            end else begin
              ram_raddr  = '0;
              state_next = dltq_pkg::S_SCAN;
            end
          end
          dltq_pkg::CMD_ADVANCE: begin
            if (cnt != '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = '{virt: head_virt, gap: '0, task_id: head_task};
            end
            state_next = dltq_pkg::S_DONE;
          end
          dltq_pkg::CMD_POP: begin
            if (cnt > CW'(1) && head_gap == '0) begin
              ram_raddr  = AW'(1);
              state_next = dltq_pkg::S_POP;
            end else begin
              state_next = dltq_pkg::S_DONE;
            end
          end
          default: begin
            state_next = dltq_pkg::S_DONE;
          end
        endcase
      end
      dltq_pkg::S_SCAN: begin
        if (stop) begin
          ram_raddr  = cnt_dec[AW-1:0];
          state_next = dltq_pkg::S_SHIFT;
        end else if (idx_inc == cnt) begin
          state_next = dltq_pkg::S_INSERT;
        end else begin
          ram_raddr = idx_inc[AW-1:0];
        end
      end
      dltq_pkg::S_SHIFT: begin
        // move entry idx up one slot; the successor of the new task has new_gap taken off its gap
        ram_we    = 1'b1;
        ram_waddr = idx_inc[AW-1:0];
        ram_wdata = ram_rdata;
        if (idx == pos) begin
          ram_wdata.gap = ram_rdata.gap - new_gap;
          state_next    = dltq_pkg::S_INSERT;
        end else begin
          ram_raddr = idx_dec[AW-1:0];
        end
      end
      dltq_pkg::S_INSERT: begin
        ram_we     = 1'b1;
        ram_waddr  = pos[AW-1:0];
        ram_wdata  = '{virt: c.virt_task, gap: new_gap,
                       task_id: c.task_id[dltq_pkg::TASK_ID_BITS-1:0]};
        state_next = dltq_pkg::S_DONE;
      end
      dltq_pkg::S_POP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_dec[AW-1:0];
        ram_wdata = ram_rdata;
        // cnt already holds the reduced count
        if (idx == cnt) begin
          state_next = dltq_pkg::S_DONE;
        end else begin
          ram_raddr = idx_inc[AW-1:0];
        end
      end
      dltq_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = dltq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dltq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      real_cnt <= '0;
      now      <= '0;
    end else begin
      case (state)
        dltq_pkg::S_IDLE: begin
          if (cmd_valid) begin
            c        <= cmd_item;
            r_status <= dltq_pkg::ST_OK;
            r_oid    <= '0;
            r_ovirt  <= 1'b0;
            r_adv    <= '0;
          end
        end
        dltq_pkg::S_EXEC: begin
          case (c.cmd)
            dltq_pkg::CMD_SCHEDULE: begin
              if (full) begin
                r_status <= dltq_pkg::ST_FULL;
              end else begin
                pos     <= '0;
                new_gap <= c.delay;
                idx     <= '0;
                prior   <= '0;
              end
            end
            dltq_pkg::CMD_ADVANCE: begin
              if (cnt == '0) begin
                r_status <= dltq_pkg::ST_EMPTY;
              end else begin
                r_adv    <= head_gap;
                head_gap <= '0;
                // saturate at the top of the time range
                now      <= sum_now[TW] ? '1 : sum_now[TW-1:0];
              end
            end
            dltq_pkg::CMD_POP: begin
              if (cnt == '0) begin
                r_status <= dltq_pkg::ST_EMPTY;
              end else if (head_gap != '0) begin
                r_status <= dltq_pkg::ST_NOT_DUE;
              end else begin
                r_oid   <= 8'(head_task);
                r_ovirt <= head_virt;
                if (!head_virt) begin
                  real_cnt <= real_cnt - CW'(1);
                end
                cnt <= cnt_dec;
                idx <= CW'(1);
              end
            end
            default: begin
              cnt      <= '0;
              real_cnt <= '0;
            end
          endcase
        end
        dltq_pkg::S_SCAN: begin
          if (stop) begin
            pos     <= idx;
            new_gap <= c.delay - prior;
            idx     <= cnt_dec;
          end else begin
            prior <= due[GW-1:0];
            idx   <= idx_inc;
            if (idx_inc == cnt) begin
              pos     <= cnt;
              new_gap <= c.delay - due[GW-1:0];
            end
          end
        end
        dltq_pkg::S_SHIFT: begin
          idx <= idx_dec;
        end
        dltq_pkg::S_INSERT: begin
          cnt <= cnt + CW'(1);
          if (!c.virt_task) begin
            real_cnt <= real_cnt + CW'(1);
          end
          if (pos == '0) begin
            head_task <= c.task_id[dltq_pkg::TASK_ID_BITS-1:0];
            head_gap  <= new_gap;
            head_virt <= c.virt_task;
          end
        end
        dltq_pkg::S_POP: begin
          if (idx == CW'(1)) begin
            head_task <= ram_rdata.task_id;
            head_gap  <= ram_rdata.gap;
            head_virt <= ram_rdata.virt;
          end
          idx <= idx_inc;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.status         = r_status;
    res.out_task_id    = r_oid;
    res.out_virtual    = r_ovirt;
    res.advanced_by    = r_adv;
    res.now            = now;
    res.real_remaining = (real_cnt != '0);
    res.step_done      = (cnt == '0) || (head_gap != '0);
    res.entries        = dltq_pkg::ENTRIES_W'(cnt);
  end

endmodule

// ===== hdl/delta_list_timer_queue.sv =====
// Time-ordered task queue kept as a delta list in a 16-entry ram, one command
// at a time. Schedule scans entries one per cycle up to the insert point, then
// moves the later entries up one per cycle; each entry is either scanned or
// moved and the one at the insert point is both (read and write port of the
// ram each serve one entry a cycle); pop moves the remaining entries down one
// per cycle; advance, clear and rejected commands go straight from execute to
// done. A finished result sits in an output register, and the next command is
// taken while it waits. The head entry is mirrored in registers and a count of
// non-virtual tasks is kept, so status flags need no scan. No clearing pass
// after reset.
// depends on dltq_pkg, dltq_ram, dltq_seq
module delta_list_timer_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  dltq_pkg::cmd_item_t cmd_item,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output dltq_pkg::rsp_t      rsp_item
);

  dltq_pkg::rsp_t   res;
  logic             res_valid, res_ready;
  logic             ram_we;
  logic [dltq_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  dltq_pkg::entry_t ram_wdata, ram_rdata;
  logic [dltq_pkg::ENTRY_W-1:0] rdata_raw;

  assign ram_rdata = dltq_pkg::entry_t'(rdata_raw);

  dltq_ram #(
    .DEPTH(dltq_pkg::QUEUE_DEPTH),
    .WIDTH(dltq_pkg::ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(dltq_pkg::ENTRY_W'(ram_wdata)),
    .raddr(ram_raddr),
    .rdata(rdata_raw)
  );

  dltq_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd_item (cmd_item),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .res      (res),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  // output register frees the sequencer as soon as the result is handed over
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_item <= res;
    end
  end

endmodule

// ===== hdl/dltq_checker.sv =====
// port level checks for the delta list timer queue, bound to the top level
// depends on dltq_pkg and delta_list_timer_queue_macros.svh
`include "delta_list_timer_queue_macros.svh"

module dltq_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input dltq_pkg::rsp_t      rsp_item
);

  `DLTQ_ASSERT_NOW(a_entries_max, clk, rst, rsp_valid,
    rsp_item.entries <= dltq_pkg::ENTRIES_W'(dltq_pkg::QUEUE_DEPTH))
  `DLTQ_ASSERT_NOW(a_empty_flags, clk, rst, rsp_valid && rsp_item.entries == '0,
    rsp_item.step_done && !rsp_item.real_remaining)
  `DLTQ_ASSERT_NOW(a_full_drop, clk, rst, rsp_valid && rsp_item.status == dltq_pkg::ST_FULL,
    rsp_item.entries == dltq_pkg::ENTRIES_W'(dltq_pkg::QUEUE_DEPTH))
  `DLTQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_item))

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp_item (rsp_item)
);
